@@ rtl/core/lppd_pkg.sv @@
`timescale 1ns / 1ps

package lppd_pkg;

  // header size in bytes
  localparam logic [31:0] HDR_BYTES = 32'd16;

  // record kinds on the result channel
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } record_kind_t;

  // one result record
  typedef struct packed {
    record_kind_t kind;
    logic [31:0]  pdu_length;
    logic [31:0]  command_code;
    logic [31:0]  status_code;
    logic [31:0]  sequence_value;
    logic [7:0]   body_value;
    logic         end_of_pdu;
  } record_t;

  // handshake between the input stage and the framer
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

endpackage

@@ rtl/core/lppd_in_stage.sv @@
`timescale 1ns / 1ps

module lppd_in_stage
  import lppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  input  logic        advance,
  output stage_ctrl_t ctrl,
  output logic [7:0]  held_byte
);

  logic       valid;
  logic [7:0] data;

  // hold off the sender while the held byte cannot move on
  assign byte_stall = valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!byte_stall) begin
      valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      data <= rx_byte;
    end
  end

  assign ctrl.valid   = valid;
  assign ctrl.advance = advance;
  assign held_byte    = data;

endmodule

@@ rtl/core/lppd_framer.sv @@
`timescale 1ns / 1ps

module lppd_framer
  import lppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stage_ctrl_t ctrl,
  input  logic [7:0]  held_byte,
  output logic        has_record,
  output logic        take,
  output record_t     record
);

  logic [31:0] byte_position;
  logic [31:0] length_word;
  logic [31:0] command_word;
  logic [31:0] status_word;
  logic [31:0] sequence_word;

  logic [31:0] byte_position_next;
  logic [31:0] length_word_next;
  logic [31:0] command_word_next;
  logic [31:0] status_word_next;
  logic [31:0] sequence_word_next;

  logic        in_header;
  logic        body_last;
  logic [32:0] pos_plus_one;

  assign take      = ctrl.valid && ctrl.advance;
  assign in_header = (byte_position[31:4] == 28'd0);

  // body end test on the widened position
  assign pos_plus_one = {1'b0, byte_position} + 33'd1;
  assign body_last    = (pos_plus_one >= {1'b0, length_word});

  // header shift and framing decisions
  always_comb begin
    length_word_next   = length_word;
    command_word_next  = command_word;
    status_word_next   = status_word;
    sequence_word_next = sequence_word;
    byte_position_next = byte_position;
    has_record         = 1'b0;
    record.kind        = KIND_HEADER;
    record.body_value  = 8'd0;
    record.end_of_pdu  = 1'b0;

    if (in_header) begin
      case (byte_position[3:2])
        2'd0:    length_word_next   = {length_word[23:0], held_byte};
        2'd1:    command_word_next  = {command_word[23:0], held_byte};
        2'd2:    status_word_next   = {status_word[23:0], held_byte};
        default: sequence_word_next = {sequence_word[23:0], held_byte};
      endcase

      if (byte_position[3:0] != 4'd15) begin
        byte_position_next = byte_position + 32'd1;
      end else if (length_word_next < HDR_BYTES) begin
        // declared length too short for a header
        has_record         = 1'b1;
        record.kind        = KIND_ERROR;
        record.end_of_pdu  = 1'b1;
        byte_position_next = 32'd0;
      end else if (length_word_next == HDR_BYTES) begin
        // header only, no body
        has_record         = 1'b1;
        record.end_of_pdu  = 1'b1;
        byte_position_next = 32'd0;
      end else begin
        has_record         = 1'b1;
        byte_position_next = HDR_BYTES;
      end
    end else begin
      // body byte pass-through
      has_record         = 1'b1;
      record.kind        = KIND_BODY;
      record.body_value  = held_byte;
      record.end_of_pdu  = body_last;
      byte_position_next = body_last ? 32'd0 : pos_plus_one[31:0];
    end

    record.pdu_length     = length_word_next;
    record.command_code   = command_word_next;
    record.status_code    = status_word_next;
    record.sequence_value = sequence_word_next;
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 32'd0;
      length_word   <= 32'd0;
      command_word  <= 32'd0;
      status_word   <= 32'd0;
      sequence_word <= 32'd0;
    end else if (take) begin
      byte_position <= byte_position_next;
      length_word   <= length_word_next;
      command_word  <= command_word_next;
      status_word   <= status_word_next;
      sequence_word <= sequence_word_next;
    end
  end

endmodule

@@ rtl/core/lppd_out_stage.sv @@
`timescale 1ns / 1ps

module lppd_out_stage
  import lppd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  record_t record_in,
  output logic    advance,
  output logic    record_valid,
  input  logic    record_stall,
  output record_t record_out
);

  logic    valid;
  logic    valid_next;
  record_t data;

  // slot is free when empty or being taken this cycle
  assign advance = !valid || !record_stall;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (valid && !record_stall) begin
      valid_next = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= record_in;
    end
  end

  assign record_valid = valid;
  assign record_out   = data;

endmodule

@@ rtl/core/length_prefixed_pdu_deframer.sv @@
`timescale 1ns / 1ps
// channel   valid         stall          payload
// input     byte_valid    byte_stall     rx_byte
// output    record_valid  record_stall   record_kind, pdu_length, command_code,
//                                        status_code, sequence_value, body_value,
//                                        end_of_pdu
//
// one byte per cycle sustained while record_stall is low; a taken byte passes
// through the input register and framer logic into the result register
// header bytes other than the last give no result and leave the output idle
// rst is synchronous; the framer restarts at the first header byte
// a stalled result holds the input register, which then stalls the sender

module length_prefixed_pdu_deframer
  import lppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        record_valid,
  input  logic        record_stall,
  output logic [1:0]  record_kind,
  output logic [31:0] pdu_length,
  output logic [31:0] command_code,
  output logic [31:0] status_code,
  output logic [31:0] sequence_value,
  output logic [7:0]  body_value,
  output logic        end_of_pdu
);

  stage_ctrl_t ctrl;
  logic [7:0]  held_byte;
  logic        advance;
  logic        has_record;
  logic        take;
  record_t     rec_next;
  record_t     rec_out;

  // input register
  lppd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .ctrl       (ctrl),
    .held_byte  (held_byte)
  );

  // header capture and body framing
  lppd_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .held_byte  (held_byte),
    .has_record (has_record),
    .take       (take),
    .record     (rec_next)
  );

  // result register
  lppd_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (take && has_record),
    .record_in    (rec_next),
    .advance      (advance),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record_out   (rec_out)
  );

  assign record_kind    = rec_out.kind;
  assign pdu_length     = rec_out.pdu_length;
  assign command_code   = rec_out.command_code;
  assign status_code    = rec_out.status_code;
  assign sequence_value = rec_out.sequence_value;
  assign body_value     = rec_out.body_value;
  assign end_of_pdu     = rec_out.end_of_pdu;

endmodule

@@ verif/pdu_record_checker.sv @@
`timescale 1ns / 1ps

module pdu_record_checker
  import lppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  rx_byte,
  input  logic        record_valid,
  input  logic        record_stall,
  input  logic [1:0]  record_kind,
  input  logic [31:0] pdu_length,
  input  logic [31:0] command_code,
  input  logic [31:0] status_code,
  input  logic [31:0] sequence_value,
  input  logic [7:0]  body_value,
  input  logic        end_of_pdu,
  output int          failures,
  output int          records_owed
);

  // framer shadow: position within the pdu and the header words seen so far
  logic [31:0] frame_pos;
  logic [31:0] length_acc;
  logic [31:0] command_acc;
  logic [31:0] status_acc;
  logic [31:0] sequence_acc;

  record_t     owed_records[$];
  record_t     want;
  record_t     seen;
  logic        bad;
  logic        last_body;
  logic [31:0] pos_now;

  always @(posedge clk) begin
    if (rst) begin
      frame_pos    = '0;
      length_acc   = '0;
      command_acc  = '0;
      status_acc   = '0;
      sequence_acc = '0;
      failures     = 0;
      owed_records.delete();
    end else begin
      // compare the delivered record with the oldest prediction
      if (record_valid && !record_stall) begin
        seen = {record_kind, pdu_length, command_code, status_code, sequence_value,
                body_value, end_of_pdu};
        if (owed_records.size() == 0) begin
          if (failures < 10)
            $display("unexpected record: kind=%0d len=%h cmd=%h sts=%h seq=%h body=%h end=%b",
                     record_kind, pdu_length, command_code, status_code, sequence_value,
                     body_value, end_of_pdu);
          failures++;
        end else begin
          want = owed_records.pop_front();
          bad  = (seen.kind !== want.kind) || (seen.pdu_length !== want.pdu_length) ||
                 (seen.command_code !== want.command_code) ||
                 (seen.status_code !== want.status_code) ||
                 (seen.sequence_value !== want.sequence_value) ||
                 (seen.body_value !== want.body_value) ||
                 (seen.end_of_pdu !== want.end_of_pdu);
          if (bad) begin
            if (failures < 10) begin
              $display("record mismatch, expected: kind=%0d len=%h cmd=%h sts=%h seq=%h body=%h end=%b",
                       want.kind, want.pdu_length, want.command_code, want.status_code,
                       want.sequence_value, want.body_value, want.end_of_pdu);
              $display("                 actual:   kind=%0d len=%h cmd=%h sts=%h seq=%h body=%h end=%b",
                       seen.kind, seen.pdu_length, seen.command_code, seen.status_code,
                       seen.sequence_value, seen.body_value, seen.end_of_pdu);
            end
            failures++;
          end
        end
      end

      // predict what the accepted byte produces
      if (byte_valid && !byte_stall) begin
        pos_now = frame_pos;
        want.pdu_length = 'x;
        if (pos_now < HDR_BYTES) begin
          case (pos_now[3:2])
            2'd0: length_acc   = {length_acc[23:0], rx_byte};
            2'd1: command_acc  = {command_acc[23:0], rx_byte};
            2'd2: status_acc   = {status_acc[23:0], rx_byte};
            default: sequence_acc = {sequence_acc[23:0], rx_byte};
          endcase
          if (pos_now != HDR_BYTES - 1) begin
            frame_pos = pos_now + 1;
          end else begin
            // last header byte: header record, or a length error if too short
            want.kind           = (length_acc < HDR_BYTES) ? KIND_ERROR : KIND_HEADER;
            want.pdu_length     = length_acc;
            want.command_code   = command_acc;
            want.status_code    = status_acc;
            want.sequence_value = sequence_acc;
            want.body_value     = '0;
            want.end_of_pdu     = (length_acc <= HDR_BYTES);
            owed_records.push_back(want);
            frame_pos = (length_acc > HDR_BYTES) ? HDR_BYTES : '0;
          end
        end else begin
          // body byte passes through, marked when it closes the pdu
          last_body = ({1'b0, pos_now} + 33'd1) >= {1'b0, length_acc};
          want.kind           = KIND_BODY;
          want.pdu_length     = length_acc;
          want.command_code   = command_acc;
          want.status_code    = status_acc;
          want.sequence_value = sequence_acc;
          want.body_value     = rx_byte;
          want.end_of_pdu     = last_body;
          owed_records.push_back(want);
          frame_pos = last_body ? '0 : pos_now + 1;
        end
      end
    end
    records_owed = owed_records.size();
  end

endmodule

@@ verif/length_prefixed_pdu_deframer_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_pdu_deframer_tb
  import lppd_pkg::*;
;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BYTES  = 317;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  rx_byte = '0;
  logic        record_valid;
  logic        record_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [31:0] pdu_length;
  logic [31:0] command_code;
  logic [31:0] status_code;
  logic [31:0] sequence_value;
  logic [7:0]  body_value;
  logic        end_of_pdu;

  int   failures;
  int   records_owed;
  int   send_gap_pct = 22;
  int   take_gap_pct = 82;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  logic hold_request = 1'b0;
  logic hold_off = 1'b0;

  length_prefixed_pdu_deframer dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .rx_byte(rx_byte),
    .record_valid(record_valid), .record_stall(record_stall),
    .record_kind(record_kind), .pdu_length(pdu_length), .command_code(command_code),
    .status_code(status_code), .sequence_value(sequence_value),
    .body_value(body_value), .end_of_pdu(end_of_pdu)
  );

  pdu_record_checker checker_i (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .rx_byte(rx_byte),
    .record_valid(record_valid), .record_stall(record_stall),
    .record_kind(record_kind), .pdu_length(pdu_length), .command_code(command_code),
    .status_code(status_code), .sequence_value(sequence_value),
    .body_value(body_value), .end_of_pdu(end_of_pdu),
    .failures(failures), .records_owed(records_owed)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst)
      record_stall <= 1'b0;
    else
      record_stall <= hold_off || ($urandom_range(99) < take_gap_pct);
  end

  // long hold-off so the block fills up and pushes back on the sender
  initial begin
    wait (hold_request);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one byte, with random gaps ahead of it, and wait until it is taken
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte    <= value;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [31:0] len, input logic [31:0] cmd,
                             input logic [31:0] sts, input logic [31:0] seq);
    logic [127:0] hdr;
    hdr = {len, cmd, sts, seq};
    for (int i = 15; i >= 0; i--)
      send_byte(hdr[i*8 +: 8]);
  endtask

  // random body byte, with the extremes now and then
  function automatic logic [7:0] body_byte();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // one random pdu: mostly well formed, some too short, some header only
  task automatic send_random_pdu();
    int          pick;
    logic [31:0] len;
    pick = $urandom_range(99);
    if (pick < 15)
      len = $urandom_range(15);
    else if (pick < 25)
      len = HDR_BYTES;
    else
      len = HDR_BYTES + $urandom_range(1, 24);
    send_header(len, $urandom(), $urandom(), $urandom());
    for (int i = HDR_BYTES; i < int'(len); i++)
      send_byte(body_byte());
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero and just-short lengths, header only, short bodies
    send_header(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_header(32'd15, 32'h0, 32'h0, 32'h0);
    send_header(HDR_BYTES, 32'h8000_0001, 32'h0000_0000, 32'h7FFF_FFFF);
    send_header(32'd17, 32'h0000_0004, 32'hFFFF_FFFF, 32'h0000_0001);
    send_byte(8'hFF);
    send_header(32'd18, 32'h8000_0004, 32'h0, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hA5);

    // sender idles little, receiver a lot
    while (bytes_sent < PHASE_BYTES) send_random_pdu();

    // the other way round
    send_gap_pct = 82;
    take_gap_pct = 22;
    while (bytes_sent < 2 * PHASE_BYTES) send_random_pdu();

    // no idling, with a long receiver hold-off at the start
    send_gap_pct = 0;
    take_gap_pct = 0;
    hold_request = 1'b1;
    while (bytes_sent < 3 * PHASE_BYTES) send_random_pdu();

    // largest declared length last, since it never completes
    send_header(32'hFFFF_FFFF, $urandom(), $urandom(), $urandom());
    for (int i = 0; i < 20; i++)
      send_byte(body_byte());
    byte_valid <= 1'b0;

    // drain, then watch for anything stray
    @(posedge clk);
    while (records_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ length_prefixed_pdu_deframer.f @@
rtl/core/lppd_pkg.sv
rtl/core/lppd_in_stage.sv
rtl/core/lppd_framer.sv
rtl/core/lppd_out_stage.sv
rtl/core/length_prefixed_pdu_deframer.sv
verif/pdu_record_checker.sv
verif/length_prefixed_pdu_deframer_tb.sv
